// ----- src/ntp_cal_pkg.sv -----
// Shared types, constants and lookup functions for the NTP seconds to calendar date block.
package ntp_cal_pkg;

   localparam int unsigned NTP_WIDTH    = 32;
   localparam int unsigned OFFSET_WIDTH = 17;
   localparam int unsigned RSP_WIDTH    = 40;

   localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_RESET = 17'sd28800;
   localparam logic signed [33:0] NTP_UNIX_DELTA = 34'sd2208988800;
   localparam logic [10:0] YEAR_BASE = 11'd1970;

   // Reciprocal constants: q_est = (x * floor(2^36 / d)) >> 36, low by at most one.
   localparam int unsigned DIV_SHIFT = 36;
   localparam logic [63:0] DIV_ONE   = 64'd1 << DIV_SHIFT;
   localparam logic [10:0] D_SIXTY   = 11'd60;
   localparam logic [10:0] D_DAY     = 11'd24;
   localparam logic [10:0] D_CYCLE   = 11'd1461;
   localparam logic [31:0] MAGIC_SIXTY = 32'(DIV_ONE / 64'd60);
   localparam logic [31:0] MAGIC_DAY   = 32'(DIV_ONE / 64'd24);
   localparam logic [31:0] MAGIC_CYCLE = 32'(DIV_ONE / 64'd1461);

   localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

   typedef enum logic [1:0] {
      DIV_SEC   = 2'd0,
      DIV_MIN   = 2'd1,
      DIV_HOUR  = 2'd2,
      DIV_CYCLE = 2'd3
   } cal_div_type;

   typedef struct packed {
      logic        load;
      logic        epoch;
      logic        mul_q;
      logic        mul_back;
      logic        fix;
      logic        year_step;
      logic        prep;
      logic        month_step;
      logic        emit;
      cal_div_type div_sel;
   } cal_cmd_type;

   typedef struct packed {
      logic before_epoch;
      logic year_done;
      logic feb29;
      logic month_done;
      logic out_free;
   } cal_status_type;

   function automatic logic [10:0] div_divisor(input cal_div_type sel);
      logic [10:0] d;
      case (sel)
         DIV_SEC:   d = D_SIXTY;
         DIV_MIN:   d = D_SIXTY;
         DIV_HOUR:  d = D_DAY;
         DIV_CYCLE: d = D_CYCLE;
         default:   d = D_SIXTY;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] div_magic(input cal_div_type sel);
      logic [31:0] m;
      case (sel)
         DIV_SEC:   m = MAGIC_SIXTY;
         DIV_MIN:   m = MAGIC_SIXTY;
         DIV_HOUR:  m = MAGIC_DAY;
         DIV_CYCLE: m = MAGIC_CYCLE;
         default:   m = MAGIC_SIXTY;
      endcase
      return m;
   endfunction

   // Common-year month lengths; index 0 is January.
   function automatic logic [4:0] month_length(input logic [3:0] idx);
      logic [4:0] len;
      case (idx)
         4'd1:                     len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- src/ntp_seconds_to_calendar_date.sv -----
// NTP era-0 seconds to local calendar date converter: top level.
//
// Each transfer on the req_ side carries an NTP seconds count (since 1900-01-01 UTC). The block
// adds the zone offset written on the csr_ port (signed seconds, reset +28800, eight hours),
// moves the count to the 1970 epoch and returns one rsp_ transfer with year, month, day, hour,
// minute and second; rsp_tuser is 1 when the local time is on or after 1970-01-01, else all
// date fields are zero. One item is worked at a time. After the accepting edge the item runs
// through the epoch shift (then straight to the result load when the local time falls before
// 1970), the four divisions on the single shared 32x32 multiplier, each a multiply, multiply-back
// and fix step (by 60, 60, 24 and 1461 days), year stepping (up to three years skipped), one
// prep step, month stepping (up to eleven months skipped; none on February 29) and the result
// load. That load waits while the previous result is still unread. The next item is accepted at
// the earliest in the cycle after the load, so a new item cannot start before the last one is
// loaded. A result held in the output register does not block acceptance of the next item.
// Write the offset only while no item is in flight.
module ntp_seconds_to_calendar_date (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_wen,
   input  logic signed [ntp_cal_pkg::OFFSET_WIDTH-1:0] csr_wdata,  // zone_offset_seconds
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [ntp_cal_pkg::NTP_WIDTH-1:0]           req_tdata,  // [31:0] ntp_seconds
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // [10:0] year, [14:11] month, [19:15] day, [24:20] hour, [30:25] minute,
   // [36:31] second, [39:37] zero
   output logic [ntp_cal_pkg::RSP_WIDTH-1:0]           rsp_tdata,
   output logic [0:0]                                  rsp_tuser   // [0] in_range
);
   import ntp_cal_pkg::*;

   cal_cmd_type    cmd;
   cal_status_type status;

   ntp_cal_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ntp_cal_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- src/ntp_cal_ctrl.sv -----
// Sequencer for the calendar conversion: steps the datapath through each phase.
module ntp_cal_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  ntp_cal_pkg::cal_status_type status,
   output ntp_cal_pkg::cal_cmd_type    cmd
);
   import ntp_cal_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_EPOCH = 9'b000000010,
      ST_MUL   = 9'b000000100,
      ST_BACK  = 9'b000001000,
      ST_FIX   = 9'b000010000,
      ST_YEAR  = 9'b000100000,
      ST_PREP  = 9'b001000000,
      ST_MONTH = 9'b010000000,
      ST_DONE  = 9'b100000000
   } cal_state_type;

   cal_state_type state_ff, state_in;
   cal_div_type   div_sel_ff, div_sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_sel_ff <= DIV_SEC;
      end else begin
         state_ff   <= state_in;
         div_sel_ff <= div_sel_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      div_sel_in  = div_sel_ff;
      cmd         = '0;
      cmd.div_sel = div_sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EPOCH;
            end
         end
         ST_EPOCH: begin
            cmd.epoch  = 1'b1;
            div_sel_in = DIV_SEC;
            state_in   = status.before_epoch ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_q = 1'b1;
            state_in  = ST_BACK;
         end
         ST_BACK: begin
            cmd.mul_back = 1'b1;
            state_in     = ST_FIX;
         end
         ST_FIX: begin
            cmd.fix = 1'b1;
            case (div_sel_ff)
               DIV_SEC: begin
                  div_sel_in = DIV_MIN;
                  state_in   = ST_MUL;
               end
               DIV_MIN: begin
                  div_sel_in = DIV_HOUR;
                  state_in   = ST_MUL;
               end
               DIV_HOUR: begin
                  div_sel_in = DIV_CYCLE;
                  state_in   = ST_MUL;
               end
               default: begin
                  state_in = ST_YEAR;
               end
            endcase
         end
         ST_YEAR: begin
            cmd.year_step = 1'b1;
            if (status.year_done) state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = status.feb29 ? ST_DONE : ST_MONTH;
         end
         ST_MONTH: begin
            cmd.month_step = 1'b1;
            if (status.month_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_cycle_then_year: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX && div_sel_ff == DIV_CYCLE) |=> state_ff == ST_YEAR)
      else $error("cycle division not followed by year stepping");

endmodule

// ----- src/ntp_cal_dp.sv -----
// Datapath: offset register, shared reciprocal divider, year/month stepping and result register.
module ntp_cal_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wen,
   input  logic signed [ntp_cal_pkg::OFFSET_WIDTH-1:0] csr_wdata,
   input  logic [ntp_cal_pkg::NTP_WIDTH-1:0]      req_tdata,
   input  logic                                   rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [ntp_cal_pkg::RSP_WIDTH-1:0]      rsp_tdata,
   output logic [0:0]                             rsp_tuser,
   input  ntp_cal_pkg::cal_cmd_type               cmd,
   output ntp_cal_pkg::cal_status_type            status
);
   import ntp_cal_pkg::*;

   logic signed [OFFSET_WIDTH-1:0] offset_ff;
   logic [31:0] work_ff;
   logic [63:0] prod_ff;
   logic [31:0] quot_ff;
   logic        neg_ff;
   logic [5:0]  second_ff, minute_ff;
   logic [4:0]  hour_ff;
   logic [10:0] year_ff;
   logic [3:0]  month_idx_ff;
   logic        rsp_valid_ff;
   logic [RSP_WIDTH-1:0] rsp_data_ff;
   logic        rsp_range_ff;

   logic signed [33:0] local_sum;
   logic [10:0] divisor;
   logic [31:0] mul_a, mul_b;
   logic [63:0] product;
   logic [11:0] rem_wide, rem_fix;
   logic        rem_over;
   logic [31:0] quot_fix;
   logic        leap;
   logic [10:0] year_len;
   logic [10:0] rest;
   logic [8:0]  doy;
   logic [4:0]  mlen;

   assign local_sum = $signed({2'b00, work_ff}) + 34'(offset_ff) - NTP_UNIX_DELTA;

   assign divisor = div_divisor(cmd.div_sel);
   assign mul_a   = cmd.mul_q ? work_ff : 32'(prod_ff[63:DIV_SHIFT]);
   assign mul_b   = cmd.mul_q ? div_magic(cmd.div_sel) : {21'd0, divisor};
   assign product = mul_a * mul_b;

   // estimate is at most one low, so the raw remainder stays below twice the divisor
   assign rem_wide = 12'(work_ff - prod_ff[31:0]);
   assign rem_over = (rem_wide >= {1'b0, divisor});
   assign rem_fix  = rem_over ? rem_wide - {1'b0, divisor} : rem_wide;
   assign quot_fix = quot_ff + {31'd0, rem_over};

   // 2000 is the only century year in reach and it is a leap year
   assign leap     = (year_ff[1:0] == 2'b00);
   assign year_len = leap ? 11'd366 : 11'd365;
   assign rest     = work_ff[10:0];
   assign doy      = work_ff[8:0];
   assign mlen     = month_length(month_idx_ff);

   assign status.before_epoch = local_sum[33];
   assign status.year_done    = (rest < year_len);
   assign status.feb29        = leap && (rest == 11'd59);
   assign status.month_done   = !((month_idx_ff < LAST_MONTH_IDX) && ({4'd0, mlen} < doy));
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_wen) begin
         offset_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) work_ff <= req_tdata;
      if (cmd.epoch) begin
         work_ff <= local_sum[31:0];
         neg_ff  <= local_sum[33];
      end
      if (cmd.mul_q) prod_ff <= product;
      if (cmd.mul_back) begin
         quot_ff <= 32'(prod_ff[63:DIV_SHIFT]);
         prod_ff <= product;
      end
      if (cmd.fix) begin
         case (cmd.div_sel)
            DIV_SEC: begin
               second_ff <= rem_fix[5:0];
               work_ff   <= quot_fix;
            end
            DIV_MIN: begin
               minute_ff <= rem_fix[5:0];
               work_ff   <= quot_fix;
            end
            DIV_HOUR: begin
               hour_ff <= rem_fix[4:0];
               work_ff <= quot_fix;
            end
            default: begin
               year_ff <= 11'(YEAR_BASE + {quot_fix[8:0], 2'b00});
               work_ff <= {20'd0, rem_fix};
            end
         endcase
      end
      if (cmd.year_step && !status.year_done) begin
         work_ff <= work_ff - {21'd0, year_len};
         year_ff <= year_ff + 11'd1;
      end
      if (cmd.prep) begin
         if (status.feb29) begin
            work_ff      <= 32'd29;
            month_idx_ff <= 4'd1;
         end else begin
            // drop Feb 29 from the count past it in a leap year
            work_ff      <= (leap && rest > 11'd59) ? work_ff : work_ff + 32'd1;
            month_idx_ff <= 4'd0;
         end
      end
      if (cmd.month_step && !status.month_done) begin
         work_ff      <= work_ff - {27'd0, mlen};
         month_idx_ff <= month_idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (neg_ff) begin
            rsp_data_ff  <= '0;
            rsp_range_ff <= 1'b0;
         end else begin
            rsp_data_ff  <= {3'd0, second_ff, minute_ff, hour_ff, work_ff[4:0],
                             month_idx_ff + 4'd1, year_ff};
            rsp_range_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_range_ff;

   a_second_below_sixty: assert property (@(posedge clock) disable iff (reset)
      (cmd.fix && cmd.div_sel == DIV_SEC) |=> second_ff < 6'd60)
      else $error("seconds remainder out of range");

   a_rest_within_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.year_step |-> work_ff < 32'd1461)
      else $error("day count exceeds four-year cycle");

   a_date_fields_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !neg_ff) |=> (rsp_tdata[14:11] != 4'd0 && rsp_tdata[14:11] <= 4'd12
                                 && rsp_tdata[19:15] != 5'd0))
      else $error("month or day out of range in result");

endmodule

// ----- verif/testbench.sv -----
// Testbench for the NTP seconds to local calendar date converter, self-checking.
`timescale 1ns / 1ps

module testbench;
   import ntp_cal_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 300000;
   localparam int unsigned ITEMS_PER_PHASE  = 177;
   localparam int unsigned PHASE_COUNT      = 7;
   localparam int unsigned DRAIN_CYCLES     = 40;
   localparam int unsigned HOLD_OFF_CYCLES  = 400;
   localparam int unsigned HOLD_OFF_TRIGGER = 60;
   localparam longint     UNIX_EPOCH_NTP    = 64'sd2208988800;
   localparam longint     SECONDS_PER_DAY   = 64'sd86400;

   typedef struct packed {
      logic [10:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        in_range;
   } civil_date_type;

   typedef struct packed {
      logic [31:0]    ntp;
      logic           typed;
      civil_date_type want;
   } date_row_type;

   localparam civil_date_type NO_DATE = '0;

   // Hand-written expectations assume the reset zone offset of +8 hours.
   localparam date_row_type DATE_ROWS [16] = '{
      '{32'd0,          1'b1, NO_DATE},
      '{32'd2208959999, 1'b1, NO_DATE},
      '{32'd2208960000, 1'b1, {11'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
      '{32'd2209046399, 1'b1, {11'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 1'b1}},
      '{32'hFFFFFFFF,   1'b0, NO_DATE},
      '{32'hFFFFFFFE,   1'b0, NO_DATE},
      '{32'd3160742399, 1'b1, {11'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b1}},
      '{32'd3160742400, 1'b1, {11'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 1'b1}},
      '{32'd3160828800, 1'b1, {11'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0, 1'b1}},
      '{32'd3187267199, 1'b1, {11'd2000, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b1}},
      '{32'd2277129600, 1'b0, NO_DATE},
      '{32'd2335190399, 1'b0, NO_DATE},
      '{32'h7FFFFFFF,   1'b1, NO_DATE},
      '{32'h55555555,   1'b1, NO_DATE},
      '{32'h80000000,   1'b0, NO_DATE},
      '{32'hAAAAAAAA,   1'b0, NO_DATE}
   };

   localparam int unsigned DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic                              clock;
   logic                              reset;
   logic                              csr_wen;
   logic signed [OFFSET_WIDTH-1:0]    csr_wdata;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [NTP_WIDTH-1:0]              req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [RSP_WIDTH-1:0]              rsp_tdata;
   logic [0:0]                        rsp_tuser;

   logic signed [OFFSET_WIDTH-1:0]    zone_offset;
   civil_date_type                    pending_dates [$];
   int unsigned                       mismatch_count = 0;
   int unsigned                       accepted_count;
   int unsigned                       cycle_count = 0;
   bit                                quiet;

   ntp_seconds_to_calendar_date i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // Local civil date of an NTP count under the given zone offset.
   function automatic civil_date_type civil_date_of(input logic [31:0] ntp,
                                                    input logic signed [OFFSET_WIDTH-1:0] offset);
      longint           local_s;
      longint unsigned  s;
      longint unsigned  hours;
      longint unsigned  rest;
      longint unsigned  doy;
      longint unsigned  year_hours;
      int unsigned      y;
      int unsigned      m;
      civil_date_type   d;
      d = '0;
      local_s = longint'({32'd0, ntp}) + longint'(offset) - UNIX_EPOCH_NTP;
      if (local_s < 0)
         return d;
      s = local_s;
      d.second = 6'(s % 60);
      s = s / 60;
      d.minute = 6'(s % 60);
      hours = s / 60;
      y = 1970 + 4 * int'(hours / (1461 * 24));
      rest = hours % (1461 * 24);
      for (int i = 0; i < 4; i++) begin
         year_hours = (leap_year(y) ? 64'd366 : 64'd365) * 64'd24;
         if (rest < year_hours)
            break;
         rest -= year_hours;
         y++;
      end
      d.hour = 5'(rest % 24);
      doy = rest / 24 + 1;
      if (leap_year(y) && doy == 60) begin
         m = 2;
         doy = 64'd29;
      end else begin
         if (leap_year(y) && doy > 60)
            doy--;
         m = 0;
         while (m < 11 && DAYS_IN_MONTH[m] < doy) begin
            doy -= DAYS_IN_MONTH[m];
            m++;
         end
         m++;
      end
      d.year = 11'(y);
      d.month = 4'(m);
      d.day = 5'(doy);
      d.in_range = 1'b1;
      return d;
   endfunction

   // Mostly valid local times, weighted toward the epoch and midnight edges.
   function automatic logic [31:0] pick_ntp(input logic signed [OFFSET_WIDTH-1:0] offset);
      longint      epoch_ntp;
      longint      v;
      int unsigned sel;
      epoch_ntp = UNIX_EPOCH_NTP - longint'(offset);
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1:    v = longint'($urandom);
         2:       v = epoch_ntp + longint'($urandom_range(0, 200)) - 100;
         3, 4:    v = epoch_ntp + longint'($urandom_range(0, 24143)) * SECONDS_PER_DAY
                      + longint'($urandom_range(0, 4)) - 2;
         default: v = epoch_ntp + longint'($urandom) % (64'sd4294967296 - epoch_ntp);
      endcase
      if (v < 0 || v > 64'sd4294967295)
         v = longint'($urandom);
      return v[31:0];
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_request(input logic [31:0] ntp, input bit typed,
                               input civil_date_type want);
      while (!quiet && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ntp;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_dates.push_back(typed ? want : civil_date_of(ntp, zone_offset));
      accepted_count++;
   endtask

   task automatic write_zone_offset(input logic signed [OFFSET_WIDTH-1:0] value);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      zone_offset = value;
   endtask

   // Result side: random back-pressure plus one long hold-off to fill the block.
   initial begin
      int unsigned    hold_left;
      bit             hold_done;
      civil_date_type got;
      civil_date_type want;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[10:0], rsp_tdata[14:11], rsp_tdata[19:15], rsp_tdata[24:20],
                   rsp_tdata[30:25], rsp_tdata[36:31], rsp_tuser[0]};
            if (pending_dates.size() == 0) begin
               $error("result transfer with no date pending");
               mismatch_count++;
            end else begin
               want = pending_dates.pop_front();
               check_field("year", want.year, got.year);
               check_field("month", want.month, got.month);
               check_field("day", want.day, got.day);
               check_field("hour", want.hour, got.hour);
               check_field("minute", want.minute, got.minute);
               check_field("second", want.second, got.second);
               check_field("in_range", want.in_range, got.in_range);
            end
         end
         if (!hold_done && accepted_count >= HOLD_OFF_TRIGGER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(!quiet && $urandom_range(0, 99) < 6);
         end
      end
   end

   initial begin
      logic signed [OFFSET_WIDTH-1:0] phase_offsets [PHASE_COUNT];
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      accepted_count = 0;
      quiet = 1'b0;
      zone_offset = OFFSET_RESET;
      // Phase 0 runs on the reset value; the rest cover -43200 to 50400 seconds and the raw extremes.
      phase_offsets = '{OFFSET_RESET, -17'sd43200, 17'sd50400, 17'sd0, -17'sd65536, 17'sd65535,
                        OFFSET_WIDTH'($urandom_range(0, 93600) - 43200)};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DATE_ROWS[i])
         send_request(DATE_ROWS[i].ntp, DATE_ROWS[i].typed, DATE_ROWS[i].want);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            while (pending_dates.size() != 0)
               @(posedge clock);
            write_zone_offset(phase_offsets[phase]);
         end
         quiet = (phase == 3);
         repeat (ITEMS_PER_PHASE)
            send_request(pick_ntp(zone_offset), 1'b0, NO_DATE);
         req_tvalid <= 1'b0;
      end

      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
